[hw/rtl/sync_marker_deframer_macros.svh]
// Assertion macros shared by the deframer checker.
// Each macro expects clk and rst_n in scope.
`ifndef SYNC_MARKER_DEFRAMER_MACROS_SVH
`define SYNC_MARKER_DEFRAMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/smd_pkg.sv]
// Shared types and constants of the sync marker deframer.
// No dependencies; imported by every deframer module.
package smd_pkg;

  localparam int MAX_PAYLOAD_LIMIT = 1024;
  localparam int COUNT_CEIL        = 2046;
  localparam int EFF_CEIL_INT      = (MAX_PAYLOAD_LIMIT < COUNT_CEIL) ?
                                     MAX_PAYLOAD_LIMIT : COUNT_CEIL;
  localparam logic [10:0] EFF_CEIL = 11'(EFF_CEIL_INT);

  localparam logic [7:0] SYNC_B0 = 8'h00;
  localparam logic [7:0] SYNC_B1 = 8'h20;
  localparam logic [7:0] SYNC_B2 = 8'h80;
  localparam logic [7:0] SYNC_B3 = 8'h12;

  localparam logic [3:0]  HEADER_LEN       = 4'd12;
  localparam logic [10:0] DEFAULT_MAX      = 11'd1024;
  localparam logic [15:0] DEFAULT_DURATION = 16'h0014;

  // Register indexes of the configuration port
  localparam logic REG_MAX_PAYLOAD    = 1'b0;
  localparam logic REG_FRAME_DURATION = 1'b1;

  // Descriptor status codes
  localparam logic [1:0] STATUS_GOOD  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_LONG  = 2'd2;

  // All results caused by one input item: payload bytes first, then a descriptor.
  typedef struct packed {
    logic [2:0]       n_bytes;
    logic [3:0][7:0]  bytes;
    logic             desc;
    logic [10:0]      length;
    logic [15:0]      timing;
    logic [1:0]       status;
  } smd_bundle_t;

  // Clamp a written maximum to the hardware ceiling.
  function automatic logic [10:0] smd_eff_max(input logic [10:0] m);
    return (m > EFF_CEIL) ? EFF_CEIL : m;
  endfunction

endpackage

[hw/rtl/smd_core.sv]
// Deframer core: marker window, header/payload counters and configuration.
// Builds the result bundle of each accepted item that causes results and holds it in a register.
// Depends on smd_pkg.
module smd_core import smd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_stream,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output smd_bundle_t pend_r,
  output logic        pend_valid_r,
  input  logic        pend_take
);

  logic        in_frame_r, in_frame_nxt;
  logic [7:0]  win_r [3];
  logic [7:0]  win_nxt [3];
  logic [1:0]  fill_r, fill_nxt;
  logic [3:0]  hc_r, hc_nxt;
  logic [10:0] pc_r, pc_nxt;
  logic [10:0] eff_max_r;
  logic [15:0] duration_r;
  smd_bundle_t bundle;
  logic        accept;
  logic        match;
  logic        has_result;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !pend_valid_r || pend_take;
  assign cfg_ready = 1'b1;

  assign match = (fill_r == 2'd3) && (win_r[0] == SYNC_B0) && (win_r[1] == SYNC_B1) &&
                 (win_r[2] == SYNC_B2) && (in_data_byte == SYNC_B3);

  always_comb begin
    logic [7:0]  seq [4];
    logic [3:0]  hc;
    logic [10:0] pc;
    logic [2:0]  nb;
    logic        act;
    logic        clear;
    seq[0] = win_r[0];
    seq[1] = win_r[1];
    seq[2] = win_r[2];
    seq[3] = in_data_byte;
    hc     = hc_r;
    pc     = pc_r;
    nb     = 3'd0;
    bundle = '0;
    clear  = 1'b0;
    in_frame_nxt = in_frame_r;
    // Release bytes leaving the window: the oldest on a full window, all held
    // bytes plus the current one at end of stream.
    for (int k = 0; k < 4; k++) begin
      if (in_end_of_stream) begin
        act = (3'(k) + {1'b0, fill_r}) >= 3'd3;
      end else begin
        act = (k == 0) && (fill_r == 2'd3);
      end
      if (act && in_frame_r && !match) begin
        if (hc < HEADER_LEN) begin
          hc = hc + 4'd1;
        end else begin
          bundle.bytes[nb[1:0]] = seq[k];
          nb = nb + 3'd1;
          if (pc <= eff_max_r) begin
            pc = pc + 11'd1;
          end
        end
      end
    end
    bundle.n_bytes = nb;
    bundle.length  = (pc > eff_max_r) ? eff_max_r : pc;
    bundle.timing  = duration_r;
    if (pc == 11'd0) begin
      bundle.status = STATUS_EMPTY;
    end else if (pc > eff_max_r) begin
      bundle.status = STATUS_LONG;
    end else begin
      bundle.status = STATUS_GOOD;
    end

    if (!in_frame_r) begin
      if (match && !in_end_of_stream) begin
        in_frame_nxt = 1'b1;
        clear = 1'b1;
      end else if (in_end_of_stream) begin
        clear = 1'b1;
      end
    end else if (match || in_end_of_stream) begin
      bundle.desc  = 1'b1;
      in_frame_nxt = match && !in_end_of_stream;
      clear = 1'b1;
    end

    hc_nxt     = clear ? 4'd0 : hc;
    pc_nxt     = clear ? 11'd0 : pc;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = in_data_byte;
    if (clear) begin
      fill_nxt = 2'd0;
    end else begin
      fill_nxt = (fill_r == 2'd3) ? fill_r : fill_r + 2'd1;
    end
    if (!bundle.desc) begin
      bundle.length = '0;
      bundle.timing = '0;
      bundle.status = STATUS_GOOD;
    end
  end

  assign has_result = (bundle.n_bytes != 3'd0) || bundle.desc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      fill_r       <= 2'd0;
      hc_r         <= 4'd0;
      pc_r         <= 11'd0;
      pend_valid_r <= 1'b0;
      eff_max_r    <= smd_eff_max(DEFAULT_MAX);
      duration_r   <= DEFAULT_DURATION;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MAX_PAYLOAD:    eff_max_r  <= smd_eff_max(cfg_data[10:0]);
          REG_FRAME_DURATION: duration_r <= cfg_data;
          default:            duration_r <= duration_r;
        endcase
      end
      if (accept) begin
        in_frame_r   <= in_frame_nxt;
        fill_r       <= fill_nxt;
        hc_r         <= hc_nxt;
        pc_r         <= pc_nxt;
        pend_valid_r <= has_result;
      end else if (pend_take) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  // Window and bundle are payload: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r[0] <= win_nxt[0];
      win_r[1] <= win_nxt[1];
      win_r[2] <= win_nxt[2];
      if (has_result) begin
        pend_r <= bundle;
      end
    end
  end

endmodule

[hw/rtl/smd_serializer.sv]
// Output stage: takes one result bundle and hands out its results one per cycle while out_ready is high.
// Depends on smd_pkg.
module smd_serializer import smd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  smd_bundle_t pend,
  input  logic        pend_valid,
  output logic        pend_take,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output logic [10:0] out_frame_length,
  output logic [15:0] out_frame_timing,
  output logic [1:0]  out_frame_status,
  output logic        out_last
);

  logic [2:0]      n_r;
  logic            desc_r;
  logic [3:0][7:0] bytes_r;
  logic [10:0]     length_r;
  logic [15:0]     timing_r;
  logic [1:0]      status_r;
  logic            fire;
  logic            on_desc;

  assign on_desc   = (n_r == 3'd0);
  assign out_valid = !on_desc || desc_r;
  assign out_kind  = on_desc;
  assign out_byte  = on_desc ? 8'd0 : bytes_r[0];
  assign out_frame_length = on_desc ? length_r : 11'd0;
  assign out_frame_timing = on_desc ? timing_r : 16'd0;
  assign out_frame_status = on_desc ? status_r : STATUS_GOOD;
  assign out_last  = on_desc || ((n_r == 3'd1) && !desc_r);

  assign fire      = out_valid && out_ready;
  assign pend_take = pend_valid && (!out_valid || (fire && out_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= 3'd0;
      desc_r <= 1'b0;
    end else if (pend_take) begin
      n_r    <= pend.n_bytes;
      desc_r <= pend.desc;
    end else if (fire) begin
      if (!on_desc) begin
        n_r <= n_r - 3'd1;
      end else begin
        desc_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_take) begin
      bytes_r  <= pend.bytes;
      length_r <= pend.length;
      timing_r <= pend.timing;
      status_r <= pend.status;
    end else if (fire && !on_desc) begin
      // advance to the next held payload byte
      bytes_r <= {8'd0, bytes_r[3:1]};
    end
  end

endmodule

[hw/rtl/sync_marker_deframer.sv]
// Sync marker deframer, top level.
// Input channel: one stream byte per item (in_data_byte, in_end_of_stream).
// Output channel: payload bytes (out_kind 0) and end-of-frame descriptors
// (out_kind 1) with length, timing word and status; out_last marks the last
// result caused by one input byte. The marker 00 20 80 12 opens a frame, the
// 12 header bytes after it are dropped, and payload is held three bytes back.
// Configuration: cfg_index 0 max_payload, 1 frame_duration; always ready.
// It must be written by the user only while the block is idle; the block itself
// does not enforce this. Throughput: one item per cycle while each item
// causes at most one result and the receiver is ready; an item that ends a
// frame at end of stream causes up to five results, sent one per cycle by
// the output stage, which sets the rate for those items.
// One finished bundle waits in the core register while the output stage
// drains the previous one, so input stops while a waiting result is not yet taken.
// Reset: hunting for a marker, empty window, max_payload 1024, duration 20.
// When the receiver stalls, the output holds and input stops once the
// bundle register is full.
// Depends on smd_pkg, smd_core and smd_serializer.
module sync_marker_deframer import smd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_stream,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output logic [10:0] out_frame_length,
  output logic [15:0] out_frame_timing,
  output logic [1:0]  out_frame_status,
  output logic        out_last
);

  smd_bundle_t pend;
  logic        pend_valid;
  logic        pend_take;

  smd_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pend_r           (pend),
    .pend_valid_r     (pend_valid),
    .pend_take        (pend_take)
  );

  smd_serializer u_ser (
    .clk              (clk),
    .rst_n            (rst_n),
    .pend             (pend),
    .pend_valid       (pend_valid),
    .pend_take        (pend_take),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_byte         (out_byte),
    .out_frame_length (out_frame_length),
    .out_frame_timing (out_frame_timing),
    .out_frame_status (out_frame_status),
    .out_last         (out_last)
  );

endmodule

[hw/rtl/smd_checker.sv]
// Port-level checker of the deframer and its bind to the top level.
// Depends on smd_pkg and sync_marker_deframer_macros.svh.
`include "sync_marker_deframer_macros.svh"

module smd_checker import smd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_data_byte,
  input logic        in_end_of_stream,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        cfg_index,
  input logic [15:0] cfg_data,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [7:0]  out_byte,
  input logic [10:0] out_frame_length,
  input logic [15:0] out_frame_timing,
  input logic [1:0]  out_frame_status,
  input logic        out_last
);

  `SMD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_byte) && $stable(out_last), "stalled result changed")
  `SMD_ASSERT_NOW(a_desc_last, out_valid && out_kind, out_last && (out_byte == 8'd0), "descriptor not last or carries a byte")
  `SMD_ASSERT_NOW(a_byte_clean, out_valid && !out_kind, (out_frame_length == 11'd0) && (out_frame_timing == 16'd0) && (out_frame_status == STATUS_GOOD), "payload item carries descriptor fields")
  `SMD_ASSERT_NOW(a_status_len, out_valid && out_kind && (out_frame_status != STATUS_LONG), (out_frame_length == 11'd0) == (out_frame_status == STATUS_EMPTY), "descriptor length disagrees with status")

endmodule

bind sync_marker_deframer smd_checker u_smd_checker (.*);

[bench/testbench.sv]
// Testbench for sync_marker_deframer: directed streams, then random framed streams.
// Predicts each result from a tracking model of the deframer and checks it in order.
// Depends on smd_pkg and the deframer RTL only.
`timescale 1ns / 100ps

module testbench;
  import smd_pkg::*;

  localparam int QUIET_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 6;
  localparam int RANDOM_ITEMS   = 130;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [10:0] length;
    logic [15:0] timing;
    logic [1:0]  status;
    logic        last;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_stream = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_MAX_PAYLOAD;
  logic [15:0] cfg_data = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic [10:0] out_frame_length;
  logic [15:0] out_frame_timing;
  logic [1:0]  out_frame_status;
  logic        out_last;

  sync_marker_deframer u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tracking copy of the deframer state and its registers
  logic        synced;
  logic [7:0]  held [3];
  int          held_cnt;
  int          hdr_seen;
  int          pay_seen;
  logic [10:0] cur_max = DEFAULT_MAX;
  logic [15:0] cur_duration = DEFAULT_DURATION;

  frame_result_t pending_results[$];
  int            errors;
  int            bytes_sent;
  int            src_gap;
  int            sink_gap;
  int            quiet_cycles;

  function automatic int payload_cap();
    return (cur_max > EFF_CEIL) ? int'(EFF_CEIL) : int'(cur_max);
  endfunction

  function automatic void post(logic kind, logic [7:0] data, logic [10:0] len,
                               logic [1:0] status);
    frame_result_t r;
    r.kind   = kind;
    r.data   = data;
    r.length = len;
    r.timing = kind ? cur_duration : 16'h0000;
    r.status = status;
    r.last   = 1'b0;
    pending_results.push_back(r);
  endfunction

  function automatic void restart(logic open);
    synced   = open;
    held     = '{default: 8'h00};
    held_cnt = 0;
    hdr_seen = 0;
    pay_seen = 0;
  endfunction

  function automatic void hold(logic [7:0] b);
    held[0] = held[1];
    held[1] = held[2];
    held[2] = b;
    if (held_cnt < 3) held_cnt++;
  endfunction

  // Drop a header byte or forward a payload byte leaving the window.
  function automatic void release_held(logic [7:0] b);
    if (hdr_seen < HEADER_LEN) begin
      hdr_seen++;
    end else begin
      post(1'b0, b, 11'd0, STATUS_GOOD);
      if (pay_seen < payload_cap() + 1) pay_seen++;
    end
  endfunction

  function automatic void close_frame();
    int cap;
    cap = payload_cap();
    if (pay_seen == 0) post(1'b1, 8'h00, 11'd0, STATUS_EMPTY);
    else if (pay_seen > cap) post(1'b1, 8'h00, 11'(cap), STATUS_LONG);
    else post(1'b1, 8'h00, 11'(pay_seen), STATUS_GOOD);
  endfunction

  function automatic void deframe_byte(logic [7:0] b, logic eos);
    frame_result_t tail;
    int            base;
    logic          marker;
    base   = pending_results.size();
    marker = held_cnt == 3 && held[0] == SYNC_B0 && held[1] == SYNC_B1 &&
             held[2] == SYNC_B2 && b == SYNC_B3;
    if (!synced) begin
      if (marker && !eos) restart(1'b1);
      else if (eos) restart(1'b0);
      else hold(b);
    end else if (marker) begin
      close_frame();
      restart(!eos);
    end else begin
      if (held_cnt == 3) release_held(held[0]);
      hold(b);
      if (eos) begin
        // drain what the window still holds, then close
        for (int i = 3 - held_cnt; i < 3; i++) release_held(held[i]);
        close_frame();
        restart(1'b0);
      end
    end
    if (pending_results.size() > base) begin
      tail = pending_results.pop_back();
      tail.last = 1'b1;
      pending_results.push_back(tail);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0b byte %02h",
                                  out_kind, out_byte));
      end else begin
        want = pending_results.pop_front();
        check_field("out_kind", 16'(out_kind), 16'(want.kind));
        check_field("out_byte", 16'(out_byte), 16'(want.data));
        check_field("out_frame_length", 16'(out_frame_length), 16'(want.length));
        check_field("out_frame_timing", out_frame_timing, want.timing);
        check_field("out_frame_status", 16'(out_frame_status), 16'(want.status));
        check_field("out_last", 16'(out_last), 16'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_gap);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        src_gap  = 29;
        sink_gap = 87;
      end
      1: begin
        src_gap  = 87;
        sink_gap = 29;
      end
      default: begin
        src_gap  = 0;
        sink_gap = 0;
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < src_gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
    deframe_byte(b, eos);
    bytes_sent++;
  endtask

  task automatic send_marker(input logic eos_last);
    send_byte(SYNC_B0, 1'b0);
    send_byte(SYNC_B1, 1'b0);
    send_byte(SYNC_B2, 1'b0);
    send_byte(SYNC_B3, eos_last);
  endtask

  // Hold input low until every expected result is out, then let the core settle.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_MAX_PAYLOAD) cur_max = value[10:0];
    else cur_duration = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly random bytes, with marker bytes mixed in to provoke partial matches.
  function automatic logic [7:0] stream_byte();
    case ($urandom_range(0, 11))
      0: return SYNC_B0;
      1: return SYNC_B1;
      2: return SYNC_B2;
      3: return SYNC_B3;
      default: return 8'($urandom);
    endcase
  endfunction

  // Noise, an almost-marker and end of stream while hunting: no result.
  task automatic test_hunting_noise();
    send_byte(8'hFF, 1'b0);
    send_byte(SYNC_B0, 1'b0);
    send_byte(SYNC_B1, 1'b0);
    send_byte(SYNC_B2, 1'b0);
    send_byte(8'h13, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_quiet();
  endtask

  // Marker right after a marker, then end of stream inside the header.
  task automatic test_empty_frames();
    send_marker(1'b0);
    send_marker(1'b0);
    send_byte(SYNC_B3, 1'b1);
    wait_quiet();
  endtask

  // Payload forwarded under the default maximum, then the maximum drops to
  // zero mid-frame and a marker on the last byte closes it as too long.
  task automatic test_max_lowered_in_frame();
    send_marker(1'b0);
    for (int k = 0; k < HEADER_LEN; k++) send_byte(k[0] ? 8'hFF : 8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    wait_quiet();
    write_reg(REG_MAX_PAYLOAD, 16'h0000);
    send_marker(1'b1);
    wait_quiet();
  endtask

  task automatic test_random_streams();
    int framed;
    int start;
    int n;
    int ending;
    int cap;
    framed = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_quiet();
      set_idling(phase / 2);
      case (phase)
        0: cap = 3;
        1: cap = 0;
        2: cap = int'(DEFAULT_MAX);
        3: cap = 1;
        default: cap = $urandom_range(2, 12);
      endcase
      write_reg(REG_MAX_PAYLOAD, 16'(cap));
      case (phase)
        0: write_reg(REG_FRAME_DURATION, 16'hFFFF);
        1: write_reg(REG_FRAME_DURATION, 16'h0000);
        default: write_reg(REG_FRAME_DURATION, 16'($urandom));
      endcase
      while (framed < (phase + 1) * RANDOM_ITEMS / PHASES) begin
        case ($urandom_range(0, 9))
          0: begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
          end
          1: begin
            n = $urandom_range(1, 3);
            send_byte(SYNC_B0, 1'b0);
            if (n > 1) send_byte(SYNC_B1, 1'b0);
            if (n > 2) send_byte(SYNC_B2, 1'b0);
            send_byte(8'($urandom), 1'b0);
          end
          default: begin
            start = bytes_sent;
            send_marker(1'b0);
            if ($urandom_range(0, 7) == 0) begin
              // header cut short by end of stream
              repeat ($urandom_range(0, 11)) send_byte(stream_byte(), 1'b0);
              send_byte(stream_byte(), 1'b1);
            end else begin
              repeat (HEADER_LEN) send_byte(stream_byte(), 1'b0);
              n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 6);
              ending = $urandom_range(0, 3);
              for (int k = 0; k < n; k++)
                send_byte(stream_byte(), ending == 0 && k == n - 1);
              if (ending == 0 && n == 0) send_byte(stream_byte(), 1'b1);
              else if (ending == 1) send_marker(1'b1);
              // otherwise leave the frame open for the next marker
            end
            framed += bytes_sent - start;
          end
        endcase
      end
    end
    wait_quiet();
  endtask

  initial begin
    errors     = 0;
    bytes_sent = 0;
    restart(1'b0);
    set_idling(0);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_hunting_noise();
    test_empty_frames();
    test_max_lowered_in_frame();
    test_random_streams();
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/smd_pkg.sv
hw/rtl/smd_core.sv
hw/rtl/smd_serializer.sv
hw/rtl/sync_marker_deframer.sv
hw/rtl/smd_checker.sv
bench/testbench.sv
